// ===== rtl/core/htfd_pkg.sv =====
`default_nettype none

package htfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_DATA = 6;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned BUSY_BIT   = 7;

    // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no reflection, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Scaling: value = raw * mul / 10486, quotient by reciprocal multiply
    localparam int unsigned RAW_W       = 20;
    localparam int unsigned MUL_W       = 8;
    localparam int unsigned PROD_W      = RAW_W + MUL_W;
    localparam int unsigned QUOT_W      = 15;
    localparam int unsigned DIV_W       = 14;
    localparam int unsigned RECIP_SHIFT = 28;
    localparam logic [DIV_W-1:0]  SCALE_DIV = 14'd10486;
    // floor(2^28 / 10486)
    localparam logic [QUOT_W-1:0] RECIP     = 15'd25599;
    localparam logic [MUL_W-1:0]  HUM_MUL   = 8'd100;
    localparam logic [MUL_W-1:0]  TEMP_MUL  = 8'd200;
    localparam logic [31:0]       TEMP_OFFSET = 32'd5000;

    // Error register reset value, -9999
    localparam logic [31:0] ERROR_RESET = 32'hFFFF_D8F1;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_BUSY  = 2'd1,
        ST_CRC   = 2'd2
    } t_status;

    // Load enables of the three scaling stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    // One byte through the CRC, one bit per step
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htfd_if.sv =====
`default_nettype none

// Byte input channel
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Result channel
interface htfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] humidity;
    logic [31:0] temperature;

    modport source (output valid, output status, output humidity, output temperature,
                    input ready);
    modport sink   (input valid, input status, input humidity, input temperature,
                    output ready);
endinterface

// Error value register write channel
interface htfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] fault_value;

    modport source (output valid, output fault_value, input ready);
    modport sink   (input valid, input fault_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/htfd_byte_cell.sv =====
`default_nettype none

module htfd_byte_cell
    import htfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_byte
);

    logic [7:0] r_byte;

    // Take the neighbor's byte on every shift beat
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ===== rtl/core/htfd_scale.sv =====
`default_nettype none

module htfd_scale
    import htfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_pipe_en          i_en,
    input  wire logic [RAW_W-1:0]  i_raw,
    input  wire logic [MUL_W-1:0]  i_mul,
    output logic      [QUOT_W-1:0] o_quot
);

    localparam int unsigned EST_W = PROD_W + QUOT_W;
    localparam int unsigned CHK_W = QUOT_W + DIV_W;

    logic [PROD_W-1:0] r_x1;
    logic [PROD_W-1:0] r_x2;
    logic [QUOT_W-1:0] r_est2;
    logic [QUOT_W-1:0] r_est3;
    logic [QUOT_W-1:0] r_rem3;

    logic [EST_W-1:0]  n_est_prod;
    logic [CHK_W-1:0]  n_back_prod;
    logic [CHK_W-1:0]  n_rem;

    // Estimate is the true quotient or one below it
    assign n_est_prod  = EST_W'(r_x1) * EST_W'(RECIP);
    assign n_back_prod = CHK_W'(r_est2) * CHK_W'(SCALE_DIV);
    assign n_rem       = CHK_W'(r_x2) - n_back_prod;

    // s1: raw times scale, s2: reciprocal estimate, s3: remainder
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x1 <= PROD_W'(i_raw) * PROD_W'(i_mul);
        end
        if (i_en.s2) begin
            r_x2   <= r_x1;
            r_est2 <= n_est_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (i_en.s3) begin
            r_est3 <= r_est2;
            r_rem3 <= n_rem[QUOT_W-1:0];
        end
    end

    // One correction step
    assign o_quot = r_est3 + QUOT_W'(r_rem3 >= QUOT_W'(SCALE_DIV));

endmodule

`default_nettype wire

// ===== rtl/core/humidity_temp_frame_decoder_core.sv =====
`default_nettype none

// Decoder for the seven-byte measurement response of a humidity/temperature
// sensor. Bytes come in one per beat on i_in, frame_start marking byte 0; the
// block takes a byte in every cycle, stalling only when its result pipeline and
// output register are full and o_out is not ready. Bytes 0..5 shift through a
// row of six byte cells while a CRC-8 (0x31, init 0xFF) runs over them; byte 6
// is the checksum and starts one result, which passes through three scaling
// stages (multiply, reciprocal estimate, remainder) and then the output
// register before it is presented on o_out. Status is 0 valid,
// 1 busy (values 0), 2 checksum error (both values carry the error register).
// Values are in hundredths: humidity = raw*100/10486,
// temperature = raw*200/10486 - 5000.
// The error register is written on i_cfg, resets to -9999, and must only be
// changed while no frame is in flight.

module humidity_temp_frame_decoder_core
    import htfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    htfd_in_if.sink   i_in,
    htfd_cfg_if.sink  i_cfg,
    htfd_out_if.source o_out
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_crc;
    logic [31:0]      r_fault_value;

    logic             r_v1, r_v2, r_v3;
    t_status          r_st1, r_st2, r_st3;

    logic             r_out_valid;
    t_status          r_status;
    logic [31:0]      r_humidity;
    logic [31:0]      r_temperature;

    logic             can_out, can3, can2, can1;
    logic             in_beat;
    logic             restart;
    logic [POS_W-1:0] eff_pos;
    logic [7:0]       eff_crc;
    logic             store_byte;
    logic             fire;
    t_status          n_status;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
    logic [QUOT_W-1:0] hum_q;
    logic [QUOT_W-1:0] temp_q;
    t_pipe_en         pipe_en;

    logic [7:0]       cell_q [FRAME_DATA];

    // Stall chain: a stage loads when it is empty or its successor moves
    assign can_out = !r_out_valid || o_out.ready;
    assign can3    = !r_v3 || can_out;
    assign can2    = !r_v2 || can3;
    assign can1    = !r_v1 || can2;

    assign i_in.ready  = can1;
    assign in_beat     = i_in.valid && can1;
    assign i_cfg.ready = 1'b1;

    // Frame position: start flag or an out-of-range position restarts
    assign restart    = i_in.frame_start || (r_pos > POS_W'(FRAME_DATA));
    assign eff_pos    = restart ? '0 : r_pos;
    assign eff_crc    = restart ? CRC_INIT : r_crc;
    assign store_byte = in_beat && (eff_pos < POS_W'(FRAME_DATA));
    assign fire       = in_beat && (eff_pos == POS_W'(FRAME_DATA));

    // Byte cells: newest byte in cell 0, byte 0 ends up in the last cell
    for (genvar g = 0; g < FRAME_DATA; g++) begin : g_cell
        if (g == 0) begin : g_head
            htfd_byte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (store_byte),
                .i_byte  (i_in.rx_byte),
                .o_byte  (cell_q[g])
            );
        end else begin : g_body
            htfd_byte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (store_byte),
                .i_byte  (cell_q[g-1]),
                .o_byte  (cell_q[g])
            );
        end
    end

    // Raw fields: cell 4 = byte 1 ... cell 0 = byte 5
    assign hum_raw  = {cell_q[4], cell_q[3], cell_q[2][7:4]};
    assign temp_raw = {cell_q[2][3:0], cell_q[1], cell_q[0]};

    // Busy is checked before the checksum
    always_comb begin
        if (cell_q[FRAME_DATA-1][BUSY_BIT]) begin
            n_status = ST_BUSY;
        end else if (i_in.rx_byte != eff_crc) begin
            n_status = ST_CRC;
        end else begin
            n_status = ST_VALID;
        end
    end

    // Position and CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else if (store_byte) begin
            r_pos <= eff_pos + POS_W'(1);
            r_crc <= crc8_step(eff_crc, i_in.rx_byte);
        end else if (fire) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end
    end

    // Error register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_value <= ERROR_RESET;
        end else if (i_cfg.valid) begin
            r_fault_value <= i_cfg.fault_value;
        end
    end

    assign pipe_en = '{s1: can1, s2: can2, s3: can3};

    htfd_scale u_hum_scale (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_raw  (hum_raw),
        .i_mul  (HUM_MUL),
        .o_quot (hum_q)
    );

    htfd_scale u_temp_scale (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_raw  (temp_raw),
        .i_mul  (TEMP_MUL),
        .o_quot (temp_q)
    );

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (can1) begin
                r_v1 <= fire;
            end
            if (can2) begin
                r_v2 <= r_v1;
            end
            if (can3) begin
                r_v3 <= r_v2;
            end
            if (can_out) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Status travels alongside the scaling stages
    always_ff @(posedge i_clk) begin
        if (can1) begin
            r_st1 <= n_status;
        end
        if (can2) begin
            r_st2 <= r_st1;
        end
        if (can3) begin
            r_st3 <= r_st2;
        end
    end

    // Output register: pick values by status
    always_ff @(posedge i_clk) begin
        if (can_out) begin
            r_status <= r_st3;
            case (r_st3)
                ST_VALID: begin
                    r_humidity    <= 32'(hum_q);
                    r_temperature <= 32'(temp_q) - TEMP_OFFSET;
                end
                ST_CRC: begin
                    r_humidity    <= r_fault_value;
                    r_temperature <= r_fault_value;
                end
                default: begin
                    r_humidity    <= '0;
                    r_temperature <= '0;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.humidity    = r_humidity;
    assign o_out.temperature = r_temperature;

endmodule

`default_nettype wire
